/* hw/rtl/assert_macros.svh */
// assertion helpers for the merger checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/khm_pkg.sv */
`timescale 1ns / 1ps
package khm_pkg;
	localparam int MaxRunsDefault = 16;
	localparam int KeyW = 32;
	localparam int RunOutW = 4;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_START   = 2'd1,
		ACT_REFILL  = 2'd2,
		ACT_EXHAUST = 2'd3
	} action_t;

	// datapath commands from the controller
	typedef struct packed {
		logic load;      // append a run head at the fill count
		logic refill;    // overwrite root key
		logic exhaust;   // mark root exhausted
		logic sift_step; // one compare-and-swap level at the cursor
		logic sift_set;  // set cursor to given position
		logic merge_set; // enter merge phase
	} dp_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic full;
		logic merging;
		logic all_done;
		logic sift_done;
	} dp_stat_t;
endpackage

/* hw/rtl/khm_stream_if.sv */
`timescale 1ns / 1ps
interface khm_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/kway_heap_merger.sv */
`timescale 1ns / 1ps
// K-way merge engine: load requests append run heads (run numbers in load order),
// a start request heapifies and returns the minimum, and each refill or
// exhausted request for the run at the root returns the next minimum, or all_done
// once every run is retired. Items are handled one at a time by a sequencer
// over a single compare-and-swap unit that handles one heap level per cycle.
// A refill or exhausted request sets the cursor to the root, then moves the new
// root down one level at a time; a start does the same from each internal node
// in turn, last node first. The result then waits in the report state until the
// result side can take it, and sits in an output register while the next request
// is taken.
module kway_heap_merger #(
	parameter int MAX_RUNS = khm_pkg::MaxRunsDefault
) (
	input  logic clk,
	input  logic arst_n,
	khm_stream_if.sink in_ch,
	khm_stream_if.source out_ch
);
	localparam int CntW = $clog2(MAX_RUNS + 1);
	khm_pkg::dp_cmd_t cmd;
	khm_pkg::dp_stat_t stat;
	logic [CntW-1:0] half_cnt, sift_pos;
	logic signed [khm_pkg::KeyW-1:0] root_key;
	logic [khm_pkg::RunOutW-1:0] root_run;
	logic res_push, out_valid_q;
	logic [khm_pkg::KeyW+khm_pkg::RunOutW:0] out_q;

	khm_ctrl #(.MAX_RUNS(MAX_RUNS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_action(in_ch.data[1:0]),
		.stat(stat), .half_cnt(half_cnt), .cmd(cmd), .sift_pos(sift_pos),
		.res_push(res_push), .res_free(!out_valid_q || out_ch.ready)
	);

	khm_datapath #(.MAX_RUNS(MAX_RUNS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sift_pos(sift_pos),
		.key(in_ch.data[khm_pkg::KeyW+1:2]), .stat(stat), .half_cnt(half_cnt),
		.root_key(root_key), .root_run(root_run)
	);

	// output register: {all_done, min_run, min_key}
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (res_push) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_push)
			out_q <= stat.all_done ? {1'b1, {(khm_pkg::KeyW+khm_pkg::RunOutW){1'b0}}}
				: {1'b0, root_run, root_key};
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
endmodule

/* hw/rtl/khm_datapath.sv */
`timescale 1ns / 1ps
module khm_datapath #(
	parameter int MAX_RUNS = khm_pkg::MaxRunsDefault,
	localparam int IdxW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1,
	localparam int CntW = $clog2(MAX_RUNS + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  khm_pkg::dp_cmd_t cmd,
	input  logic [CntW-1:0] sift_pos,
	input  logic signed [khm_pkg::KeyW-1:0] key,
	output khm_pkg::dp_stat_t stat,
	output logic [CntW-1:0] half_cnt,
	output logic signed [khm_pkg::KeyW-1:0] root_key,
	output logic [khm_pkg::RunOutW-1:0] root_run
);
	logic signed [khm_pkg::KeyW-1:0] keys_q [MAX_RUNS];
	logic [IdxW-1:0] runs_q [MAX_RUNS];
	logic [MAX_RUNS-1:0] exh_q;
	logic [CntW-1:0] loaded_q, finished_q, cur_q;
	logic merging_q, done_q;

	// child positions, wide enough to compare against the count
	logic [CntW+1:0] lpos, rpos, best;
	logic [IdxW-1:0] li, ri, ci, bi;
	logic l_ok, r_ok, l_lt, r_lt;
	logic [CntW+1:0] cur_w;

	function automatic logic ent_less(logic ea, logic signed [khm_pkg::KeyW-1:0] ka,
			logic eb, logic signed [khm_pkg::KeyW-1:0] kb);
		ent_less = ea ? 1'b0 : (eb ? 1'b1 : (ka < kb));
	endfunction

	// one sift level: choose smallest of cursor and its children
	always_comb begin
		cur_w = {2'b00, cur_q};
		lpos = (cur_w << 1) + 1'b1;
		rpos = lpos + 1'b1;
		ci = cur_q[IdxW-1:0];
		li = lpos[IdxW-1:0];
		ri = rpos[IdxW-1:0];
		l_ok = lpos < {2'b00, loaded_q};
		r_ok = rpos < {2'b00, loaded_q};
		l_lt = l_ok && ent_less(exh_q[li], keys_q[li], exh_q[ci], keys_q[ci]);
		best = l_lt ? lpos : cur_w;
		bi = l_lt ? li : ci;
		r_lt = r_ok && ent_less(exh_q[ri], keys_q[ri], exh_q[bi], keys_q[bi]);
		if (r_lt) begin
			best = rpos;
			bi = ri;
		end
	end

	// status and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exh_q <= '0;
			loaded_q <= '0;
			finished_q <= '0;
			cur_q <= '0;
			merging_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				exh_q[loaded_q[IdxW-1:0]] <= 1'b0;
				loaded_q <= loaded_q + 1'b1;
			end
			if (cmd.merge_set) merging_q <= 1'b1;
			if (cmd.exhaust) begin
				exh_q[0] <= 1'b1;
				finished_q <= finished_q + 1'b1;
			end
			if (cmd.sift_set) begin
				cur_q <= sift_pos;
				done_q <= 1'b0;
			end else if (cmd.sift_step) begin
				if (best == cur_w) done_q <= 1'b1;
				else begin
					cur_q <= best[CntW-1:0];
					exh_q[ci] <= exh_q[bi];
					exh_q[bi] <= exh_q[ci];
				end
			end
		end
	end

	// key and run storage
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			keys_q[loaded_q[IdxW-1:0]] <= key;
			runs_q[loaded_q[IdxW-1:0]] <= loaded_q[IdxW-1:0];
		end
		if (cmd.refill) keys_q[0] <= key;
		if (cmd.sift_step && !cmd.sift_set && best != cur_w) begin
			keys_q[ci] <= keys_q[bi];
			keys_q[bi] <= keys_q[ci];
			runs_q[ci] <= runs_q[bi];
			runs_q[bi] <= runs_q[ci];
		end
	end

	assign stat.full = (loaded_q == CntW'(MAX_RUNS));
	assign stat.merging = merging_q;
	assign stat.all_done = (finished_q >= loaded_q);
	assign stat.sift_done = done_q || (cur_q >= loaded_q);
	assign half_cnt = loaded_q >> 1;
	assign root_key = keys_q[0];
	assign root_run = khm_pkg::RunOutW'({{khm_pkg::RunOutW{1'b0}}, runs_q[0]});
endmodule

/* hw/rtl/khm_ctrl.sv */
`timescale 1ns / 1ps
module khm_ctrl #(
	parameter int MAX_RUNS = khm_pkg::MaxRunsDefault,
	localparam int CntW = $clog2(MAX_RUNS + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] in_action,
	input  khm_pkg::dp_stat_t stat,
	input  logic [CntW-1:0] half_cnt,
	output khm_pkg::dp_cmd_t cmd,
	output logic [CntW-1:0] sift_pos,
	output logic res_push,
	input  logic res_free
);
	typedef enum logic [2:0] {
		S_IDLE, S_BUILD_SET, S_BUILD, S_SIFT_SET, S_SIFT, S_REPORT
	} state_t;
	state_t state_q;
	logic [CntW-1:0] bidx_q;
	logic take;

	assign in_ready = (state_q == S_IDLE);
	assign take = in_valid && in_ready;

	// command decode
	always_comb begin
		cmd = '0;
		sift_pos = '0;
		res_push = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					if (!stat.merging) begin
						cmd.load = (in_action == khm_pkg::ACT_LOAD) && !stat.full;
						cmd.merge_set = (in_action == khm_pkg::ACT_START);
					end else if (!stat.all_done) begin
						cmd.refill = (in_action == khm_pkg::ACT_REFILL);
						cmd.exhaust = (in_action == khm_pkg::ACT_EXHAUST);
					end
				end
			end
			S_BUILD_SET: begin
				cmd.sift_set = 1'b1;
				sift_pos = bidx_q - 1'b1;
			end
			S_BUILD: cmd.sift_step = 1'b1;
			S_SIFT_SET: cmd.sift_set = 1'b1;
			S_SIFT: cmd.sift_step = 1'b1;
			S_REPORT: res_push = res_free;
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bidx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (!stat.merging) begin
							if (in_action == khm_pkg::ACT_START) begin
								bidx_q <= half_cnt;
								state_q <= (half_cnt == '0) ? S_REPORT : S_BUILD_SET;
							end
						end else if (in_action inside {khm_pkg::ACT_REFILL,
								khm_pkg::ACT_EXHAUST}) begin
							state_q <= stat.all_done ? S_REPORT : S_SIFT_SET;
						end
					end
				end
				S_BUILD_SET: begin
					bidx_q <= bidx_q - 1'b1;
					state_q <= S_BUILD;
				end
				S_BUILD: begin
					if (stat.sift_done)
						state_q <= (bidx_q == '0) ? S_REPORT : S_BUILD_SET;
				end
				S_SIFT_SET: state_q <= S_SIFT;
				S_SIFT: if (stat.sift_done) state_q <= S_REPORT;
				S_REPORT: if (res_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hw/rtl/khm_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module khm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [36:0] out_data
);
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`ASSERT_IMP(a_done_zero, clk, arst_n, out_valid && out_data[36], out_data[35:0] == 36'd0)
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready || !out_valid || out_ready || $stable(out_data))
endmodule

bind kway_heap_merger khm_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
